// File: rtl/core/isdf_pkg.sv
// ----------------------------------------------------------------------------
// isdf_pkg
// Shared constants, function codes and controller/datapath structs for the
// integer set difference filter.
// ----------------------------------------------------------------------------
package isdf_pkg;

  localparam int SET_DEPTH_DEF = 64;
  localparam int FUNC_W        = 2;
  localparam int VALUE_W       = 32;

  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FILTER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic STATUS_PASS = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  typedef struct packed {
    logic accept;
    logic write;
    logic clear;
    logic scan_start;
    logic rd_issue;
    logic emit;
    logic emit_drop;
  } isdf_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              idx_last;
    logic              hit;
    logic              out_free;
  } isdf_sts_t;

endpackage

// File: rtl/core/isdf_item_if.sv
// ----------------------------------------------------------------------------
// isdf_item_if
// Input channel: function code and signed value with valid/ready.
// ----------------------------------------------------------------------------
interface isdf_item_if;
  import isdf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);

endinterface

// File: rtl/core/isdf_result_if.sv
// ----------------------------------------------------------------------------
// isdf_result_if
// Output channel: kept or dropped value and status with valid/ready.
// ----------------------------------------------------------------------------
interface isdf_result_if;
  import isdf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_res;
  logic                      status;

  modport source (output valid, output value_res, output status, input ready);
  modport sink   (input valid, input value_res, input status, output ready);

endinterface

// File: rtl/core/isdf_datapath.sv
// ----------------------------------------------------------------------------
// isdf_datapath
// Entry memory, entry count, scan index, compare and output register.
// ----------------------------------------------------------------------------
module isdf_datapath #(
  parameter int SET_DEPTH = isdf_pkg::SET_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  isdf_pkg::isdf_cmd_t                cmd,
  output isdf_pkg::isdf_sts_t                sts,
  input  logic [isdf_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [isdf_pkg::VALUE_W-1:0] in_value,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic signed [isdf_pkg::VALUE_W-1:0] res_value,
  output logic                               res_status
);
  import isdf_pkg::*;

  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CW = $clog2(SET_DEPTH + 1);

  logic signed [VALUE_W-1:0] mem [SET_DEPTH];

  logic [FUNC_W-1:0]         item_func;
  logic signed [VALUE_W-1:0] item_value;
  logic [CW-1:0]             count;
  logic [AW-1:0]             idx;
  logic signed [VALUE_W-1:0] rd_data;
  logic                      rd_valid;
  logic [CW-1:0]             count_m1;

  assign count_m1 = count - CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_func  <= in_func;
      item_value <= in_value;
    end
    if (cmd.write) begin
      mem[count[AW-1:0]] <= item_value;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.write) begin
        count <= count + CW'(1);
      end
      if (cmd.scan_start) begin
        idx <= '0;
      end else if (cmd.rd_issue) begin
        idx <= idx + AW'(1);
      end
      rd_valid <= cmd.rd_issue;
    end
  end

  // output register, free when empty or being taken this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_value  <= item_value;
      res_status <= cmd.emit_drop ? STATUS_DROP : STATUS_PASS;
    end
  end

  always_comb begin
    sts.func     = item_func;
    sts.full     = (count == CW'(SET_DEPTH));
    sts.empty    = (count == '0);
    sts.idx_last = (CW'(idx) == count_m1);
    sts.hit      = rd_valid && (rd_data == item_value);
    sts.out_free = !res_valid || res_ready;
  end

endmodule

// File: rtl/core/isdf_ctrl.sv
// ----------------------------------------------------------------------------
// isdf_ctrl
// Sequencer: accepts one item, decodes it, runs the entry scan for a filter
// and hands results to the output register.
// ----------------------------------------------------------------------------
module isdf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  isdf_pkg::isdf_sts_t sts,
  output isdf_pkg::isdf_cmd_t cmd
);
  import isdf_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.func)
          FUNC_LOAD: begin
            if (sts.full) begin
              state_next = ST_EMIT;
            end else begin
              cmd.write  = 1'b1;
              state_next = ST_IDLE;
            end
          end
          FUNC_FILTER: begin
            if (sts.empty) begin
              state_next = ST_EMIT;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end
          FUNC_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        // hit refers to the read issued in the previous cycle
        if (sts.hit) begin
          state_next = ST_IDLE;
        end else begin
          cmd.rd_issue = 1'b1;
          if (sts.idx_last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_next = sts.hit ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_drop = (sts.func == FUNC_LOAD);
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/integer_set_difference_filter.sv
// ----------------------------------------------------------------------------
// integer_set_difference_filter
// Drops stream values found in a stored exclusion set; load, filter, clear.
//
//   channel  dir  payload                  role
//   item     in   func[1:0], value[31:0]   load / filter / clear transaction
//   result   out  value_res[31:0], status  kept value or dropped load
//
// load, clear and unused codes go from decode straight back to idle; a load
// into a full set and a filter on an empty set go through the emit state; a
// filter scans the entry memory through its single read port, one entry per
// cycle, then drains the last read and emits if it finds no match; a match
// ends the scan early and drops the transaction.
// rst is synchronous; it empties the set, no clearing pass is needed.
// a stalled result waits in the output register; the next transaction is
// still accepted and only a second result waits for it to drain.
// ----------------------------------------------------------------------------
module integer_set_difference_filter #(
  parameter int SET_DEPTH = isdf_pkg::SET_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  isdf_item_if.sink    item,
  isdf_result_if.source result
);
  import isdf_pkg::*;

  isdf_cmd_t cmd;
  isdf_sts_t sts;
  logic      in_ready;

  assign item.ready = in_ready;

  isdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  isdf_datapath #(
    .SET_DEPTH (SET_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (item.func),
    .in_value   (item.value),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_value  (result.value_res),
    .res_status (result.status)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("accepted a transaction while one was in progress");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result overwrote a pending result");

  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> !sts.full)
    else $error("write into a full set");

  a_scan_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> !sts.empty)
    else $error("scan read issued on an empty set");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_set_difference_filter. A queue of load,
// filter and clear transactions is driven with random gaps, results are taken
// with random stalls and one long hold-off, and every result is compared
// against a local model of the exclusion set.
// ----------------------------------------------------------------------------
module tb;
  import isdf_pkg::*;

  localparam int DEPTH = SET_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 700;
  localparam int QUIET_TAIL = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 60;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      status;
  } result_t;

  logic clk;
  logic rst;

  isdf_item_if   item_bus ();
  isdf_result_if res_bus ();

  integer_set_difference_filter i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (res_bus)
  );

  item_t   item_queue[$];
  result_t due_results[$];

  // exclusion set as the block should hold it
  logic signed [VALUE_W-1:0] set_mem [DEPTH];
  int set_count = 0;

  logic quiet = 1'b0;
  int err_cnt = 0;
  int n_items = 0;
  int n_results = 0;
  int n_kept = 0;
  int n_removed = 0;
  int n_dropped = 0;
  int n_clears = 0;

  task automatic predict_item(input item_t it);
    result_t r;
    logic hit;
    hit = 1'b0;
    case (it.func)
      FUNC_LOAD: begin
        if (set_count < DEPTH) begin
          set_mem[set_count] = it.value;
          set_count++;
        end else begin
          r.value = it.value;
          r.status = STATUS_DROP;
          due_results.insert(due_results.size(), r);
          n_dropped++;
        end
      end
      FUNC_FILTER: begin
        for (int i = 0; i < set_count; i++) begin
          if (set_mem[i] == it.value) hit = 1'b1;
        end
        if (hit) begin
          n_removed++;
        end else begin
          r.value = it.value;
          r.status = STATUS_PASS;
          due_results.insert(due_results.size(), r);
          n_kept++;
        end
      end
      FUNC_CLEAR: begin
        set_count = 0;
        n_clears++;
      end
      default: ;
    endcase
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
      1: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_item(logic [FUNC_W-1:0] f, logic signed [VALUE_W-1:0] v);
    item_t it;
    it.func = f;
    it.value = v;
    item_queue.insert(item_queue.size(), it);
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver
  item_t drive_item;
  int gap_left = 0;
  int gap_pct = 10;

  always @(posedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        predict_item(drive_item);
        n_items++;
        if (n_items % 50 == 0) gap_pct = pick_idle_pct();
      end
      if (!item_bus.valid || item_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_bus.valid <= 1'b0;
        end else if (item_queue.size() > 0) begin
          drive_item = item_queue.pop_front();
          item_bus.valid <= 1'b1;
          item_bus.func <= drive_item.func;
          item_bus.value <= drive_item.value;
          if (!quiet && $urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 5);
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
      quiet <= (item_queue.size() < QUIET_TAIL);
    end
  end

  // monitor and receiver
  int hold_left = 0;
  int stall_pct = 10;
  bit held_long = 1'b0;
  result_t want;

  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        n_results++;
        if (n_results % 50 == 0) stall_pct = pick_idle_pct();
        if (due_results.size() == 0) begin
          $error("unexpected result transaction: value_res %0d status %0d",
                 res_bus.value_res, res_bus.status);
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          if (res_bus.value_res !== want.value) begin
            $error("value_res mismatch: expected %0d, actual %0d",
                   want.value, res_bus.value_res);
            err_cnt++;
          end
          if (res_bus.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, res_bus.status);
            err_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (!held_long && n_results == HOLD_AFTER) begin
        // long back-pressure so the block fills and stalls its input
        held_long = 1'b1;
        hold_left = HOLD_CYCLES;
        res_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        hold_left = $urandom_range(0, 4);
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  int still_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready))
        still_cycles = 0;
      else
        still_cycles++;
      if (still_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: watchdog expired after %0d idle cycles", still_cycles);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic signed [VALUE_W-1:0] pool[$];
    logic signed [VALUE_W-1:0] v;
    int n_directed;
    int n_load;
    int n_filt;

    rst = 1'b1;
    item_bus.valid = 1'b0;
    item_bus.func = FUNC_LOAD;
    item_bus.value = '0;
    res_bus.ready = 1'b0;

    // directed: empty set, extremes, matches, duplicates, unused code, clear
    add_item(FUNC_FILTER, 0);
    add_item(FUNC_FILTER, VAL_MIN);
    add_item(FUNC_FILTER, VAL_MAX);
    add_item(FUNC_LOAD, VAL_MIN);
    add_item(FUNC_LOAD, VAL_MAX);
    add_item(FUNC_LOAD, 0);
    add_item(FUNC_LOAD, -1);
    add_item(FUNC_FILTER, VAL_MIN);
    add_item(FUNC_FILTER, VAL_MAX);
    add_item(FUNC_FILTER, -1);
    add_item(FUNC_FILTER, 1);
    add_item(FUNC_FILTER, 32'sh5555_5555);
    add_item(FUNC_FILTER, 32'sh2aaa_aaaa);
    add_item(FUNC_UNUSED, -1);
    add_item(FUNC_FILTER, 0);
    add_item(FUNC_LOAD, 5);
    add_item(FUNC_LOAD, 5);
    add_item(FUNC_FILTER, 5);
    add_item(FUNC_CLEAR, 0);
    add_item(FUNC_FILTER, -1);
    add_item(FUNC_FILTER, 5);
    add_item(FUNC_CLEAR, -1);
    add_item(FUNC_FILTER, VAL_MIN);
    n_directed = item_queue.size();

    // random: sometimes clear, load a batch, then filter against it
    while (item_queue.size() < n_directed + RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) != 0) begin
        add_item(FUNC_CLEAR, $urandom);
        pool.delete();
      end
      n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 6)
                                           : $urandom_range(0, 8);
      for (int i = 0; i < n_load; i++) begin
        v = rand_value();
        add_item(FUNC_LOAD, v);
        pool.insert(pool.size(), v);
      end
      n_filt = $urandom_range(1, 12);
      for (int i = 0; i < n_filt; i++) begin
        if (pool.size() > 0 && $urandom_range(0, 1) == 1) begin
          v = pool[$urandom_range(0, pool.size() - 1)];
          if ($urandom_range(0, 3) == 0) v = v + 1;
        end else begin
          v = rand_value();
        end
        add_item(FUNC_FILTER, v);
      end
      if ($urandom_range(0, 9) == 0) add_item(FUNC_UNUSED, $urandom);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (item_queue.size() > 0 || item_bus.valid || due_results.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      err_cnt++;
    end
    $display("tb: %0d item and %0d result transactions, long hold-off %0s",
             n_items, n_results, held_long ? "applied" : "not reached");
    $display("tb: %0d kept, %0d removed by match, %0d loads dropped when full, %0d clears",
             n_kept, n_removed, n_dropped, n_clears);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
